// File: sv/lbp_pkg.sv
// shared types and constants for the lsb-first bit packer
// no dependencies
`default_nettype none
package lbp_pkg;

  localparam int ACC_BITS   = 32;
  localparam int HELD_BITS  = 6;
  localparam int VALUE_BITS = 16;
  localparam int WIDTH_BITS = 5;
  localparam int MODE_BITS  = 2;
  localparam int BYTE_BITS  = 8;
  localparam int CNT_BITS   = 3;
  localparam int FLUSH_LIMIT = 16;
  localparam int FLUSH_BYTES = 2;

  localparam logic [MODE_BITS-1:0] MODE_WRITE  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_FINISH = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_CLEAR  = 2'd2;

  typedef struct packed {
    logic [ACC_BITS-1:0] data;
    logic [CNT_BITS-1:0] nbytes;
    logic                fin;
  } lbp_job_t;

endpackage
`default_nettype wire

// File: sv/lbp_front.sv
// front end: accepts items, keeps the accumulator and bit count, posts byte jobs
// depends on lbp_pkg
`default_nettype none
module lbp_front import lbp_pkg::*; #(
  parameter int MAX_FIELD_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [MODE_BITS-1:0]  in_mode,
  input  wire logic [VALUE_BITS-1:0] in_value,
  input  wire logic [WIDTH_BITS-1:0] in_width,
  output logic                       job_valid,
  output lbp_job_t                   job,
  input  wire logic                  job_ready
);

  localparam logic [WIDTH_BITS-1:0] MAX_W = WIDTH_BITS'(MAX_FIELD_BITS);

  logic [ACC_BITS-1:0]   acc_r, acc_nxt;
  logic [HELD_BITS-1:0]  held_r, held_nxt;
  logic                  accept;
  logic                  flush;
  logic [WIDTH_BITS-1:0] wsat;
  logic [VALUE_BITS:0]   mask;
  logic [VALUE_BITS-1:0] val_m;
  logic [ACC_BITS-1:0]   acc_base;
  logic [HELD_BITS-1:0]  held_base;
  logic [HELD_BITS-1:0]  fin_sum;

  assign in_ready = job_ready;
  assign accept   = in_valid && job_ready;
  assign flush    = held_r > HELD_BITS'(FLUSH_LIMIT);
  assign wsat     = (in_width > MAX_W) ? MAX_W : in_width;
  assign mask     = ((VALUE_BITS+1)'(1) << wsat) - (VALUE_BITS+1)'(1);
  assign val_m    = in_value & mask[VALUE_BITS-1:0];
  assign acc_base  = flush ? (acc_r >> FLUSH_LIMIT) : acc_r;
  assign held_base = flush ? (held_r - HELD_BITS'(FLUSH_LIMIT)) : held_r;
  assign fin_sum   = held_r + HELD_BITS'(7);

  always_comb begin
    acc_nxt   = acc_r;
    held_nxt  = held_r;
    job_valid = 1'b0;
    job.data  = acc_r;
    job.nbytes = '0;
    job.fin   = 1'b0;
    if (accept) begin
      case (in_mode)
        MODE_WRITE: begin
          acc_nxt    = acc_base | (ACC_BITS'(val_m) << held_base);
          held_nxt   = held_base + HELD_BITS'(wsat);
          job_valid  = flush;
          job.nbytes = CNT_BITS'(FLUSH_BYTES);
        end
        MODE_FINISH: begin
          job.nbytes = fin_sum[HELD_BITS-1:3];
          job.fin    = 1'b1;
          job_valid  = held_r != '0;
          acc_nxt    = '0;
          held_nxt   = '0;
        end
        MODE_CLEAR: begin
          acc_nxt  = '0;
          held_nxt = '0;
        end
        default: begin
          acc_nxt  = acc_r;
          held_nxt = held_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      held_r <= '0;
    end else begin
      acc_r  <= acc_nxt;
      held_r <= held_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/lbp_job_queue.sv
// two-entry queue of byte jobs between front and back
// depends on lbp_pkg
`default_nettype none
module lbp_job_queue import lbp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     wr_valid,
  input  wire lbp_job_t wr_job,
  output logic          wr_ready,
  output logic          rd_valid,
  output lbp_job_t      rd_job,
  input  wire logic     rd_pop
);

  lbp_job_t   mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;

  assign wr_ready = count_r != 2'd2;
  assign rd_valid = count_r != 2'd0;
  assign rd_job   = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/lbp_back.sv
// back end: takes byte jobs and sends them one byte per cycle, while out_ready allows, through an output register
// depends on lbp_pkg
`default_nettype none
module lbp_back import lbp_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 job_valid,
  input  wire lbp_job_t             job,
  output logic                      job_pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [BYTE_BITS-1:0]      out_byte,
  output logic                      out_last
);

  logic [ACC_BITS-1:0]  cur_data_r, cur_data_nxt;
  logic [CNT_BITS-1:0]  cur_cnt_r, cur_cnt_nxt;
  logic                 cur_fin_r, cur_fin_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [BYTE_BITS-1:0] out_byte_r, out_byte_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 load_out;

  assign load_out = (cur_cnt_r != '0) && (!out_valid_r || out_ready);
  assign job_pop  = job_valid &&
                    ((cur_cnt_r == '0) || ((cur_cnt_r == CNT_BITS'(1)) && load_out));

  always_comb begin
    cur_data_nxt  = cur_data_r;
    cur_cnt_nxt   = cur_cnt_r;
    cur_fin_nxt   = cur_fin_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (load_out) begin
      out_byte_nxt  = cur_data_r[BYTE_BITS-1:0];
      out_last_nxt  = cur_fin_r && (cur_cnt_r == CNT_BITS'(1));
      out_valid_nxt = 1'b1;
      cur_data_nxt  = cur_data_r >> BYTE_BITS;
      cur_cnt_nxt   = cur_cnt_r - CNT_BITS'(1);
    end
    if (job_pop) begin
      cur_data_nxt = job.data;
      cur_cnt_nxt  = job.nbytes;
      cur_fin_nxt  = job.fin;
    end
  end

  always_ff @(posedge clk) begin
    cur_data_r <= cur_data_nxt;
    cur_fin_r  <= cur_fin_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_cnt_r   <= cur_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule
`default_nettype wire

// File: sv/lsb_first_bit_packer.sv
// top level of the lsb-first bit packer: front, job queue, back
// depends on lbp_pkg, lbp_front, lbp_job_queue, lbp_back
//
// channel  dir  payload
// in_*     in   tdata: field_value, field_width; tuser: mode
// out_*    out  tdata: out_byte; tlast: last
//
// the front takes one item per cycle while the job queue has room
// a write that flushes sends two bytes, a finish up to four, one byte per cycle while out_tready allows
// sustained rate of flushing writes is set by the output byte rate
// reset clears the accumulator, bit count, queue and output valid flag
// a stalled output fills the two-entry queue before in_tready drops
`default_nettype none
module lsb_first_bit_packer import lbp_pkg::*; #(
  parameter int MAX_FIELD_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // field_value[15:0], field_width[20:16], zero pad
  input  wire logic [1:0]  in_tuser,   // mode[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // out_byte[7:0]
  output logic             out_tlast
);

  logic     fq_valid, fq_ready;
  lbp_job_t fq_job;
  logic     qb_valid, qb_pop;
  lbp_job_t qb_job;

  lbp_front #(
    .MAX_FIELD_BITS(MAX_FIELD_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_mode  (in_tuser),
    .in_value (in_tdata[VALUE_BITS-1:0]),
    .in_width (in_tdata[VALUE_BITS+WIDTH_BITS-1:VALUE_BITS]),
    .job_valid(fq_valid),
    .job      (fq_job),
    .job_ready(fq_ready)
  );

  lbp_job_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(fq_valid),
    .wr_job  (fq_job),
    .wr_ready(fq_ready),
    .rd_valid(qb_valid),
    .rd_job  (qb_job),
    .rd_pop  (qb_pop)
  );

  lbp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_valid(qb_valid),
    .job      (qb_job),
    .job_pop  (qb_pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_byte (out_tdata),
    .out_last (out_tlast)
  );

endmodule
`default_nettype wire

// File: bench/testbench.sv
// self-checking bench for lsb_first_bit_packer: directed, random and backpressure tests
// predicts every packed byte and its tlast flag and checks each output transfer
// depends on lbp_pkg and the lsb_first_bit_packer rtl
`default_nettype none
module testbench;
  import lbp_pkg::*;

  localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;
  localparam int FIELD_MAX     = 16;
  localparam int IDLE_LIMIT    = 2000;
  localparam int DRAIN_SLACK   = 20;
  localparam int LONG_HOLD     = 300;
  localparam int MAX_REPORTS   = 20;

  typedef struct packed {
    logic [BYTE_BITS-1:0] data;
    logic                 fin;
  } packed_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  packed_byte_t        pending_bytes[$];
  logic [ACC_BITS-1:0] pk_acc = '0;
  logic [HELD_BITS-1:0] pk_held = '0;

  int errors = 0;
  int items_sent = 0;
  int bytes_checked = 0;
  int frames_done = 0;
  int burst_left = 0;
  int gap_left = 0;
  int tx_gap_max = 0;
  int rx_stall_pct = 0;
  int rx_hold_request = 0;
  int rx_hold_count = 0;
  int idle_cycles = 0;

  lsb_first_bit_packer #(.MAX_FIELD_BITS(FIELD_MAX)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #2 clk = ~clk;

  task automatic push_byte(input logic [BYTE_BITS-1:0] data, input logic fin);
    packed_byte_t b;
    b.data = data;
    b.fin = fin;
    pending_bytes.push_back(b);
  endtask

  task automatic predict_packed_bytes(input logic [1:0] mode, input logic [15:0] value,
                                      input logic [4:0] width);
    int                  w;
    int                  nbytes;
    logic [16:0]         mask;
    logic [ACC_BITS-1:0] field;
    case (mode)
      MODE_WRITE: begin
        w = (width > FIELD_MAX) ? FIELD_MAX : width;
        if (pk_held > FLUSH_LIMIT) begin
          push_byte(pk_acc[7:0], 1'b0);
          push_byte(pk_acc[15:8], 1'b0);
          pk_acc = pk_acc >> 16;
          pk_held = pk_held - 6'd16;
        end
        mask = (17'd1 << w) - 17'd1;
        field = {16'd0, value & mask[15:0]};
        pk_acc = pk_acc | (field << pk_held);
        pk_held = pk_held + w[HELD_BITS-1:0];
      end
      MODE_FINISH: begin
        nbytes = (pk_held + 7) >> 3;
        for (int i = 0; i < nbytes; i++) begin
          push_byte(pk_acc[7:0], i == nbytes - 1);
          pk_acc = pk_acc >> BYTE_BITS;
        end
        pk_acc = '0;
        pk_held = '0;
        frames_done++;
      end
      MODE_CLEAR: begin
        pk_acc = '0;
        pk_held = '0;
      end
      default: ;
    endcase
  endtask

  // sender: bursts of random length, random gaps between bursts
  task automatic send_item(input logic [1:0] mode, input logic [15:0] value,
                           input logic [4:0] width);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap_left = $urandom_range(0, tx_gap_max);
    end
    burst_left--;
    if (gap_left > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap_left) @(posedge clk);
      gap_left = 0;
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, width, value};
    in_tuser  <= mode;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_packed_bytes(mode, value, width);
    if (mode != MODE_UNUSED) items_sent++;
  endtask

  task automatic pause_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rx_hold_request > 0) begin
      rx_hold_count = rx_hold_request;
      rx_hold_request = 0;
    end
    if (rx_hold_count > 0) begin
      out_tready <= 1'b0;
      rx_hold_count--;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    packed_byte_t exp_b;
    if (rst_n && out_tvalid && out_tready) begin
      bytes_checked++;
      if (pending_bytes.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected byte, expected none, actual %h last %b",
                   $time, out_tdata, out_tlast);
      end else begin
        exp_b = pending_bytes.pop_front();
        if (out_tdata !== exp_b.data || out_tlast !== exp_b.fin) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: byte mismatch, expected %h last %b, actual %h last %b",
                     $time, exp_b.data, exp_b.fin, out_tdata, out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d transfers still expected", $time, pending_bytes.size());
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_directed();
    tx_gap_max = 0;
    rx_stall_pct = 0;
    send_item(MODE_WRITE, 16'hffff, 5'd0);
    send_item(MODE_WRITE, 16'hffff, 5'd16);
    send_item(MODE_WRITE, 16'h0000, 5'd16);
    send_item(MODE_WRITE, 16'h0001, 5'd1);
    send_item(MODE_FINISH, 16'h0000, 5'd0);
    send_item(MODE_FINISH, 16'hffff, 5'd31);
    send_item(MODE_WRITE, 16'habcd, 5'd31);
    send_item(MODE_WRITE, 16'h1234, 5'd17);
    send_item(MODE_FINISH, 16'h0000, 5'd0);
    send_item(MODE_WRITE, 16'h001f, 5'd5);
    send_item(MODE_CLEAR, 16'hffff, 5'd16);
    send_item(MODE_FINISH, 16'h0000, 5'd0);
    send_item(MODE_WRITE, 16'h00a5, 5'd8);
    send_item(MODE_UNUSED, 16'hffff, 5'd31);
    send_item(MODE_FINISH, 16'h0000, 5'd0);
    send_item(MODE_WRITE, 16'hc3c3, 5'd16);
    send_item(MODE_WRITE, 16'h005a, 5'd8);
    send_item(MODE_WRITE, 16'hffff, 5'd0);
    send_item(MODE_FINISH, 16'h0000, 5'd0);
    send_item(MODE_WRITE, 16'hffff, 5'd3);
    send_item(MODE_WRITE, 16'h0000, 5'd7);
    send_item(MODE_WRITE, 16'h8001, 5'd20);
    send_item(MODE_FINISH, 16'h0000, 5'd0);
    pause_until_drained();
  endtask

  task automatic test_random_frames(input int n_items);
    int start;
    int nw;
    int w;
    start = items_sent;
    while (items_sent - start < n_items) begin
      case ($urandom_range(3))
        0: rx_stall_pct = 0;
        1: rx_stall_pct = 20;
        2: rx_stall_pct = 50;
        default: rx_stall_pct = 80;
      endcase
      tx_gap_max = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(99) < 80) begin
        nw = $urandom_range(1, 8);
        repeat (nw) begin
          w = ($urandom_range(9) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
          send_item(MODE_WRITE, 16'($urandom), 5'(w));
        end
        if ($urandom_range(9) == 0)
          send_item(MODE_CLEAR, 16'($urandom), 5'($urandom_range(0, 31)));
        else send_item(MODE_FINISH, 16'($urandom), 5'($urandom_range(0, 31)));
      end else begin
        send_item(2'($urandom_range(0, 3)), 16'($urandom), 5'($urandom_range(0, 31)));
      end
    end
    pause_until_drained();
  endtask

  // output held off while the sender keeps offering, so the input side stalls
  task automatic test_backpressure();
    tx_gap_max = 0;
    rx_stall_pct = 0;
    burst_left = 0;
    rx_hold_request = LONG_HOLD;
    repeat (3) begin
      send_item(MODE_WRITE, 16'($urandom), 5'd16);
      send_item(MODE_WRITE, 16'($urandom), 5'd16);
      send_item(MODE_WRITE, 16'($urandom), 5'($urandom_range(1, 16)));
      send_item(MODE_FINISH, 16'h0000, 5'd0);
    end
    pause_until_drained();
    rx_stall_pct = 30;
    tx_gap_max = 3;
    repeat (6) send_item(MODE_WRITE, 16'($urandom), 5'($urandom_range(0, 16)));
    pause_until_drained();
    send_item(MODE_FINISH, 16'h0000, 5'd0);
    pause_until_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_frames(120);
    test_backpressure();
    repeat (DRAIN_SLACK) @(posedge clk);
    if (pending_bytes.size() != 0) begin
      errors++;
      $display("%0t: %0d bytes expected but never seen", $time, pending_bytes.size());
    end
    $display("ran %0d items in %0d frames, %0d output bytes checked", items_sent,
             frames_done, bytes_checked);
    $display("covered zero, full and oversized widths, clears, ignored mode and stalls");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
